// File: src/swr_pkg.sv
// shared types and codes for the sequence window reservation block
// no dependencies; imported by every module under src
package swr_pkg;

  localparam int SEQ_W = 64;

  typedef logic [SEQ_W-1:0] seq_t;

  // request operation codes
  typedef enum logic [1:0] {
    OP_RESERVE  = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_COMMIT   = 2'd2,
    OP_ROLLBACK = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2,
    ST_USED = 2'd3
  } status_t;

endpackage

// File: src/sequence_window_reservation.sv
// Sequence window reservation: keeps a committed base and a reservation bitmap of
// WINDOW_SLOTS bits and runs one reserve, release, commit or rollback request per
// cycle unless the result side is held. A request is captured in an input register,
// evaluated in combinational logic (slot range check, bitmap update, top-slot
// encode and base add) and lands in a result register; out_tvalid rises when the
// result register loads, and a new request is taken every cycle while the result
// side drains. The bitmap and base update in the same cycle, so back-to-back requests
// see each other's effects. cfg_wen loads the base only while the bitmap is empty.
// depends on swr_pkg, swr_slot_map and swr_top_enc
module sequence_window_reservation #(
  parameter int OPS_PER_TX   = 256,
  parameter int WINDOW_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration: initial committed id
  input  logic                cfg_wen,
  input  swr_pkg::seq_t       cfg_wdata,
  // request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,   // [63:0] seq_number
  input  logic [1:0]          in_tuser,   // [1:0] operation
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [127:0]        out_tdata,  // [63:0] committed_base, [127:64] tentative_base
  output logic [1:0]          out_tuser   // [1:0] status
);
  import swr_pkg::*;

  // input register
  logic    in_valid_r;
  op_t     op_r;
  seq_t    seq_r;

  // block state
  seq_t                    base_r,  base_nxt;
  logic [WINDOW_SLOTS-1:0] bits_r,  bits_nxt;

  // result register
  logic    out_valid_r;
  status_t out_status_r, status_nxt;
  seq_t    out_committed_r;
  seq_t    out_tentative_r, tentative_nxt;

  status_t                 map_status;
  logic [WINDOW_SLOTS-1:0] map_mask;
  seq_t                    inc_cur, inc_nxt;
  logic                    fire;

  // handshake
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  swr_slot_map #(
    .OPS_PER_TX   (OPS_PER_TX),
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_slot_map (
    .seq_i    (seq_r),
    .base_i   (base_r),
    .status_o (map_status),
    .mask_o   (map_mask)
  );

  swr_top_enc #(
    .OPS_PER_TX   (OPS_PER_TX),
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_enc_cur (
    .bits_i (bits_r),
    .inc_o  (inc_cur)
  );

  swr_top_enc #(
    .OPS_PER_TX   (OPS_PER_TX),
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_enc_nxt (
    .bits_i (bits_nxt),
    .inc_o  (inc_nxt)
  );

  // operation decode and state update
  always_comb begin
    base_nxt   = base_r;
    bits_nxt   = bits_r;
    status_nxt = ST_OK;
    unique case (op_r)
      OP_RESERVE: begin
        status_nxt = map_status;
        if (map_status == ST_OK) begin
          if (|(bits_r & map_mask)) begin
            status_nxt = ST_USED;
          end else begin
            bits_nxt = bits_r | map_mask;
          end
        end
      end
      OP_RELEASE: begin
        status_nxt = map_status;
        if (map_status == ST_OK) begin
          bits_nxt = bits_r & ~map_mask;
        end
      end
      OP_COMMIT: begin
        base_nxt = base_r + inc_cur;
        bits_nxt = '0;
      end
      OP_ROLLBACK: begin
        bits_nxt = '0;
      end
      default: begin
        bits_nxt = bits_r;
      end
    endcase
  end

  // after commit the map is empty, so the tentative base is the new base
  assign tentative_nxt = (op_r == OP_COMMIT) ? base_nxt : base_r + inc_nxt;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= op_t'(in_tuser);
      seq_r <= in_tdata;
    end
  end

  // state registers and configuration load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      bits_r <= '0;
    end else if (fire) begin
      base_r <= base_nxt;
      bits_r <= bits_nxt;
    end else if (cfg_wen && (bits_r == '0)) begin
      base_r <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r    <= status_nxt;
      out_committed_r <= base_nxt;
      out_tentative_r <= tentative_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_tentative_r, out_committed_r};

  // commit and rollback leave an empty map
  a_clear_map: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ((op_r == OP_COMMIT) || (op_r == OP_ROLLBACK)) |=> (bits_r == '0))
    else $error("map not cleared after commit or rollback");

  // a failed reserve or release changes no state
  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (status_nxt != ST_OK) |=> (bits_r == $past(bits_r)) && (base_r == $past(base_r)))
    else $error("state changed on failed request");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a held result");

endmodule

// File: src/swr_slot_map.sv
// maps a sequence number to a one-hot window slot and range status
// depends on swr_pkg; used by sequence_window_reservation
module swr_slot_map #(
  parameter int OPS_PER_TX   = 256,
  parameter int WINDOW_SLOTS = 64
) (
  input  swr_pkg::seq_t            seq_i,
  input  swr_pkg::seq_t            base_i,
  output swr_pkg::status_t         status_o,
  output logic [WINDOW_SLOTS-1:0]  mask_o
);
  import swr_pkg::*;

  localparam int   LIM_INT = (WINDOW_SLOTS + 1) * OPS_PER_TX;
  localparam int   NW      = $clog2(LIM_INT + 1);
  localparam seq_t LIM     = SEQ_W'(LIM_INT);
  localparam seq_t OPS     = SEQ_W'(OPS_PER_TX);

  seq_t              diff;
  logic [NW-1:0]     diff_n;
  logic [WINDOW_SLOTS:0] ge;

  assign diff   = seq_i - base_i;
  assign diff_n = diff[NW-1:0];

  // thermometer of slot boundaries, valid only while diff is in range
  for (genvar k = 0; k <= WINDOW_SLOTS; k++) begin : g_thr
    assign ge[k] = (diff_n >= NW'((k + 1) * OPS_PER_TX));
  end

  // slot k covers (k+1)*ops .. (k+2)*ops-1 above the base
  for (genvar k = 0; k < WINDOW_SLOTS; k++) begin : g_mask
    assign mask_o[k] = ge[k] & ~ge[k+1];
  end

  // range check at full width
  always_comb begin
    if (seq_i <= base_i) begin
      status_o = ST_LOW;
    end else if ((diff < OPS) || (diff >= LIM)) begin
      status_o = ST_HIGH;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

// File: src/swr_top_enc.sv
// window increment: (highest reserved slot + 1) * ops per transaction
// depends on swr_pkg; used by sequence_window_reservation
module swr_top_enc #(
  parameter int OPS_PER_TX   = 256,
  parameter int WINDOW_SLOTS = 64
) (
  input  logic [WINDOW_SLOTS-1:0] bits_i,
  output swr_pkg::seq_t           inc_o
);
  import swr_pkg::*;

  localparam int CW    = $clog2(WINDOW_SLOTS + 1);
  localparam int INC_W = CW + $clog2(OPS_PER_TX + 1);

  logic [WINDOW_SLOTS-1:0] top_hot;
  logic [CW-1:0]           cnt;
  logic [INC_W-1:0]        prod;

  // one-hot of the highest set bit
  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_hot
    if (i == WINDOW_SLOTS - 1) begin : g_last
      assign top_hot[i] = bits_i[i];
    end else begin : g_mid
      assign top_hot[i] = bits_i[i] & ~(|bits_i[WINDOW_SLOTS-1:i+1]);
    end
  end

  // encode to index plus one, zero for an empty map
  always_comb begin
    cnt = '0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      cnt = cnt | (top_hot[i] ? CW'(i + 1) : CW'(0));
    end
  end

  assign prod  = INC_W'(cnt) * INC_W'(OPS_PER_TX);
  assign inc_o = SEQ_W'(prod);

endmodule
